@@ rtl/wft_pkg.sv @@
// wft_pkg: shared types and constants of the word frequency table.
// Command and status structs between controller and datapath, result codes.
// No dependencies.
package wft_pkg;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

    localparam logic [1:0] RES_COUNTED  = 2'd0;
    localparam logic [1:0] RES_NEW      = 2'd1;
    localparam logic [1:0] RES_FULL     = 2'd2;
    localparam logic [1:0] RES_TOO_LONG = 2'd3;

    typedef struct packed {
        logic       acc;      // input item accepted
        logic       tok_clr;  // drop the word in progress
        logic       e_clr;
        logic       e_inc;
        logic       e_fill;   // point entry at the first free slot
        logic       k_clr;
        logic       k_inc;
        logic       found_wr; // bump the count of the matched entry
        logic       copy_wr;  // copy one token byte into the store
        logic       new_wr;   // finish a new entry
        logic       res_set;
        logic [1:0] res_st;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic closes;    // incoming byte ends a word
        logic ovf;
        logic len_zero;
        logic fill_zero;
        logic full;
        logic e_last;
        logic len_eq;
        logic byte_eq;
        logic k_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/wft_if.sv @@
// wft_in_if / wft_out_if: valid/ready channels of the word frequency table.
// No dependencies.
interface wft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;
    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface wft_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  slot_index;
    logic [15:0] word_count;
    logic        is_name;
    logic [1:0]  status;
    modport source (output valid, output slot_index, output word_count,
                    output is_name, output status, input ready);
    modport sink   (input valid, input slot_index, input word_count,
                    input is_name, input status, output ready);
endinterface

@@ rtl/wft_ctrl.sv @@
// wft_ctrl: sequencer of the word frequency table.
// Depends on wft_pkg; drives wft_dp through t_cmd, watches t_status.
module wft_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  wft_pkg::t_status i_status,
    output logic             o_in_ready,
    output wft_pkg::t_cmd    o_cmd
);
    import wft_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_CLOSE     = 11'b00000000010,
        S_LEN_WAIT  = 11'b00000000100,
        S_LEN_CHK   = 11'b00000001000,
        S_BYTE_WAIT = 11'b00000010000,
        S_BYTE_CHK  = 11'b00000100000,
        S_FOUND     = 11'b00001000000,
        S_COPY_WAIT = 11'b00010000000,
        S_COPY_WR   = 11'b00100000000,
        S_EMIT      = 11'b01000000000,
        S_SPARE     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        t_cmd c;
        c       = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.acc = 1'b1;
                    if (i_status.closes) n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (i_status.ovf) begin
                    c.res_set = 1'b1;
                    c.res_st  = RES_TOO_LONG;
                    n_state   = S_EMIT;
                end else if (i_status.len_zero) begin
                    c.tok_clr = 1'b1;
                    n_state   = S_IDLE;
                end else if (i_status.fill_zero) begin
                    c.e_fill = 1'b1;
                    c.k_clr  = 1'b1;
                    n_state  = S_COPY_WAIT;
                end else begin
                    c.e_clr = 1'b1;
                    n_state = S_LEN_WAIT;
                end
            end
            S_LEN_WAIT:  n_state = S_LEN_CHK;
            S_BYTE_WAIT: n_state = S_BYTE_CHK;
            S_COPY_WAIT: n_state = S_COPY_WR;
            S_LEN_CHK, S_BYTE_CHK: begin
                if (r_state == S_LEN_CHK && i_status.len_eq) begin
                    c.k_clr = 1'b1;
                    n_state = S_BYTE_WAIT;
                end else if (r_state == S_BYTE_CHK && i_status.byte_eq) begin
                    if (i_status.k_last) begin
                        n_state = S_FOUND;
                    end else begin
                        c.k_inc = 1'b1;
                        n_state = S_BYTE_WAIT;
                    end
                end else if (!i_status.e_last) begin
                    c.e_inc = 1'b1;
                    n_state = S_LEN_WAIT;
                end else if (i_status.full) begin
                    c.res_set = 1'b1;
                    c.res_st  = RES_FULL;
                    n_state   = S_EMIT;
                end else begin
                    c.e_fill = 1'b1;
                    c.k_clr  = 1'b1;
                    n_state  = S_COPY_WAIT;
                end
            end
            S_FOUND: begin
                c.found_wr = 1'b1;
                c.res_set  = 1'b1;
                c.res_st   = RES_COUNTED;
                n_state    = S_EMIT;
            end
            S_COPY_WR: begin
                c.copy_wr = 1'b1;
                if (i_status.k_last) begin
                    c.new_wr  = 1'b1;
                    c.res_set = 1'b1;
                    c.res_st  = RES_NEW;
                    n_state   = S_EMIT;
                end else begin
                    c.k_inc = 1'b1;
                    n_state = S_COPY_WAIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    c.out_load = 1'b1;
                    c.tok_clr  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd = c;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.new_wr |-> !i_status.full)
        else $error("new entry written into a full table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |=> (r_state == S_IDLE || r_state == S_CLOSE))
        else $error("accepted item left controller in a search state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a pending one");
endmodule

@@ rtl/wft_dp.sv @@
// wft_dp: datapath of the word frequency table: token buffer, word store,
// per-entry length/count/name memories, fill level and result register.
// Depends on wft_pkg; commanded by wft_ctrl.
module wft_dp #(
    parameter int TABLE_ENTRIES = 128,
    parameter int MAX_WORD_LEN  = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wft_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_text_byte,
    input  logic             i_line_end,
    input  logic             i_out_ready,
    output wft_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [6:0]       o_slot_index,
    output logic [15:0]      o_word_count,
    output logic             o_is_name,
    output logic [1:0]       o_res_status
);
    import wft_pkg::*;

    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int STORE_DEPTH = TABLE_ENTRIES << KW;
    localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);
    localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_WORD_LEN);

    logic [7:0]            r_tok_mem [MAX_WORD_LEN];
    logic [7:0]            r_store   [STORE_DEPTH];
    logic [LW-1:0]         r_len_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt_mem [TABLE_ENTRIES];
    logic                  r_nm_mem  [TABLE_ENTRIES];

    logic [LW-1:0]         r_tok_len;
    logic                  r_ovf;
    logic [7:0]            r_first;
    logic [FW-1:0]         r_fill;
    logic [EW-1:0]         r_e;
    logic [KW-1:0]         r_k;
    logic [7:0]            r_tok_q, r_st_q;
    logic [LW-1:0]         r_len_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_nm_q;
    logic [EW-1:0]         r_res_slot;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_nm;
    logic [1:0]            r_res_st;
    logic                  r_out_valid;

    logic                  sep;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  first_up;

    assign sep      = (i_text_byte == CHAR_SPACE) || (i_text_byte == CHAR_COMMA);
    assign cnt_inc  = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + 1'b1;
    assign first_up = (r_first >= CHAR_UP_A) && (r_first <= CHAR_UP_Z);

    // memories, read every cycle at the current entry / byte position
    always_ff @(posedge i_clk) begin
        r_tok_q <= r_tok_mem[r_k];
        r_st_q  <= r_store[{r_e, r_k}];
        r_len_q <= r_len_mem[r_e];
        r_cnt_q <= r_cnt_mem[r_e];
        r_nm_q  <= r_nm_mem[r_e];
        if (i_cmd.acc && !sep && !r_ovf && r_tok_len < LEN_MAX) begin
            r_tok_mem[r_tok_len[KW-1:0]] <= i_text_byte;
            if (r_tok_len == '0) r_first <= i_text_byte;
        end
        if (i_cmd.copy_wr) r_store[{r_e, r_k}] <= r_tok_q;
        if (i_cmd.found_wr) r_cnt_mem[r_e] <= cnt_inc;
        if (i_cmd.new_wr) begin
            r_len_mem[r_e] <= r_tok_len;
            r_cnt_mem[r_e] <= COUNT_BITS'(1);
            r_nm_mem[r_e]  <= first_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_len   <= '0;
            r_ovf       <= 1'b0;
            r_fill      <= '0;
            r_e         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tok_clr) begin
                r_tok_len <= '0;
                r_ovf     <= 1'b0;
            end else if (i_cmd.acc && !sep && !r_ovf) begin
                if (r_tok_len < LEN_MAX) r_tok_len <= r_tok_len + 1'b1;
                else                     r_ovf     <= 1'b1;
            end
            if (i_cmd.e_clr)       r_e <= '0;
            else if (i_cmd.e_inc)  r_e <= r_e + 1'b1;
            else if (i_cmd.e_fill) r_e <= EW'(r_fill);
            if (i_cmd.k_clr)       r_k <= '0;
            else if (i_cmd.k_inc)  r_k <= r_k + 1'b1;
            if (i_cmd.new_wr)      r_fill <= r_fill + 1'b1;
            if (i_cmd.out_load)    r_out_valid <= 1'b1;
            else if (i_out_ready)  r_out_valid <= 1'b0;
        end
    end

    // result being built, then the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_st <= i_cmd.res_st;
            case (i_cmd.res_st)
                RES_COUNTED: begin
                    r_res_slot <= r_e;
                    r_res_cnt  <= cnt_inc;
                    r_res_nm   <= r_nm_q;
                end
                RES_NEW: begin
                    r_res_slot <= r_e;
                    r_res_cnt  <= COUNT_BITS'(1);
                    r_res_nm   <= first_up;
                end
                default: begin
                    r_res_slot <= '0;
                    r_res_cnt  <= '0;
                    r_res_nm   <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            o_slot_index <= 7'(r_res_slot);
            o_word_count <= 16'(r_res_cnt);
            o_is_name    <= r_res_nm;
            o_res_status <= r_res_st;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.closes    = sep || i_line_end;
        o_status.ovf       = r_ovf;
        o_status.len_zero  = (r_tok_len == '0);
        o_status.fill_zero = (r_fill == '0);
        o_status.full      = (r_fill == FILL_MAX);
        o_status.e_last    = (FW'(r_e) == r_fill - 1'b1);
        o_status.len_eq    = (r_len_q == r_tok_len);
        o_status.byte_eq   = (r_st_q == r_tok_q);
        o_status.k_last    = (LW'(r_k) == r_tok_len - 1'b1);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= FILL_MAX)
        else $error("fill level beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_tok_len <= LEN_MAX)
        else $error("token length beyond limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.found_wr |-> (FW'(r_e) < r_fill))
        else $error("count bumped on an unused entry");
endmodule

@@ rtl/word_frequency_table.sv @@
// word_frequency_table: top level, joins wft_ctrl and wft_dp.
// Depends on wft_pkg, wft_if, wft_ctrl, wft_dp.
//
// Input channel i_in carries one text byte per item with a line_end flag.
// Space, comma and line_end close a word. Each closed word gives one item on
// o_out: slot, count (saturating), name mark and status (counted, new, table
// full, too long). Separators with no word in progress give nothing.
// A byte that does not close a word is accepted in the idle state, which
// keeps input ready high. A closing byte starts a search that reads the
// stored entries one at a time through the length and word memories: a
// length check per entry, then a compare of each byte when the lengths
// match; a new word is then copied byte by byte into the store, with no
// search when the table is empty. A word that is too long skips the search
// and goes straight to the emit step.
// Input ready is low while a word is closed, searched, copied or emitted.
// The result sits in an output register; a stalled receiver holds the block
// in its emit step until the register frees, and no result is lost.
// Reset (synchronous, active low) empties the table by zeroing the fill
// level; stored data need no clearing pass.
module word_frequency_table #(
    parameter int TABLE_ENTRIES = 128,
    parameter int MAX_WORD_LEN  = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wft_in_if.sink    i_in,
    wft_out_if.source o_out
);
    import wft_pkg::*;

    t_cmd    cmd;
    t_status status;

    wft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    wft_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_text_byte  (i_in.text_byte),
        .i_line_end   (i_in.line_end),
        .i_out_ready  (o_out.ready),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .o_slot_index (o_out.slot_index),
        .o_word_count (o_out.word_count),
        .o_is_name    (o_out.is_name),
        .o_res_status (o_out.status)
    );
endmodule
